[src/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AJB_CHECK(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define AJB_CHECK_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define AJB_CHECK(name, expr)

`define AJB_CHECK_NEXT(name, pre, post)

`endif

`endif

[src/ajb_pkg.sv]
package ajb_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int BLOCK_FRAMES   = 64;
    localparam int IDX_W          = 6;
    localparam int COUNT_W        = 7;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int SAMPLE_W       = 16;
    localparam int FRAME_W        = 2 * SAMPLE_W;

    localparam logic [CFG_W-1:0] PRIME_RESET = 13'd1024;
    localparam logic [CFG_W-1:0] THR_RESET   = 13'd3072;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd1;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_RING = 2'd1,
        SRC_HELD = 2'd2
    } src_t;

    typedef struct packed {
        logic             valid;
        src_t             src;
        logic [IDX_W-1:0] idx;
        logic             fade;
    } issue_t;

endpackage

[src/ajb_ram.sv]
module ajb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/ajb_ctrl.sv]
`include "assert_macros.svh"

module ajb_ctrl #(
    parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [ajb_pkg::SAMPLE_W-1:0] in_left,
    input  logic signed [ajb_pkg::SAMPLE_W-1:0] in_right,
    input  logic                               cfg_we,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ajb_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               can_issue,
    output ajb_pkg::issue_t                    issue,
    output logic                               mem_we,
    output logic [$clog2(RING_DEPTH)-1:0]      mem_waddr,
    output logic [ajb_pkg::FRAME_W-1:0]        mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(RING_DEPTH)-1:0]      mem_raddr
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > ajb_pkg::CFG_W) ? FILL_W : ajb_pkg::CFG_W;
    localparam int CNT_W  = ajb_pkg::COUNT_W;
    localparam int IDX_W  = ajb_pkg::IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    ctrl_state_t               state_reg, state_next;
    logic [PTR_W-1:0]          rp_reg, rp_next;
    logic [PTR_W-1:0]          wp_reg, wp_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic                      primed_reg, primed_next;
    logic                      fade_pending_reg, fade_pending_next;
    logic [ajb_pkg::CFG_W-1:0] prime_reg, prime_next;
    logic [ajb_pkg::CFG_W-1:0] thr_reg, thr_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          consume_reg, consume_next;
    logic [CNT_W-1:0]          use_reg, use_next;
    logic                      silent_reg, silent_next;
    logic                      fade_blk_reg, fade_blk_next;

    logic              accept;
    logic              push;
    logic              pull;
    logic              enough;
    logic              silent;
    logic              drop;
    logic              full_read;
    logic [CNT_W-1:0]  got_raw;
    logic [FILL_W-1:0] fill_after;
    logic [PTR_W-1:0]  rp_inc;
    logic [PTR_W-1:0]  wp_inc;
    logic              fire;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign push   = accept && (req_type == ajb_pkg::REQ_PUSH);
    assign pull   = accept && (req_type == ajb_pkg::REQ_PULL);

    assign enough = CMP_W'(fill_reg) >= CMP_W'(prime_reg);
    assign silent = !primed_reg && !enough;

    assign got_raw = (fill_reg >= FILL_W'(ajb_pkg::BLOCK_FRAMES))
                   ? CNT_W'(ajb_pkg::BLOCK_FRAMES) : fill_reg[CNT_W-1:0];
    assign fill_after = fill_reg - FILL_W'(got_raw);
    assign full_read  = got_raw == CNT_W'(ajb_pkg::BLOCK_FRAMES);
    assign drop       = full_read && (CMP_W'(fill_after) > CMP_W'(thr_reg));

    assign rp_inc = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign wp_inc = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    assign fire = (state_reg == ST_RUN) && can_issue;

    always_comb
    begin
        issue.valid = fire;
        issue.idx   = k_reg;
        issue.fade  = fade_blk_reg;
        if (silent_reg)
        begin
            issue.src = ajb_pkg::SRC_ZERO;
        end
        else if ({1'b0, k_reg} < use_reg)
        begin
            issue.src = ajb_pkg::SRC_RING;
        end
        else
        begin
            issue.src = ajb_pkg::SRC_HELD;
        end
    end

    assign mem_re    = fire && (issue.src == ajb_pkg::SRC_RING);
    assign mem_raddr = rp_reg;
    assign mem_we    = push;
    assign mem_waddr = wp_reg;
    assign mem_wdata = {in_right, in_left};
    assign in_stall  = state_reg != ST_IDLE;

    always_comb
    begin
        state_next        = state_reg;
        rp_next           = rp_reg;
        wp_next           = wp_reg;
        fill_next         = fill_reg;
        primed_next       = primed_reg;
        fade_pending_next = fade_pending_reg;
        prime_next        = prime_reg;
        thr_next          = thr_reg;
        k_next            = k_reg;
        consume_next      = consume_reg;
        use_next          = use_reg;
        silent_next       = silent_reg;
        fade_blk_next     = fade_blk_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                ajb_pkg::REG_PRIME: prime_next = cfg_data;
                ajb_pkg::REG_THR:   thr_next   = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    wp_next = wp_inc;
                    if (fill_reg == FILL_W'(RING_DEPTH))
                    begin
                        rp_next = rp_inc;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                if (pull)
                begin
                    state_next    = ST_RUN;
                    k_next        = '0;
                    silent_next   = silent;
                    consume_next  = silent ? '0 : got_raw;
                    use_next      = (silent || drop) ? '0 : got_raw;
                    fade_blk_next = !silent && !drop && full_read && fade_pending_reg;
                    if (!silent)
                    begin
                        primed_next       = 1'b1;
                        fill_next         = fill_after;
                        fade_pending_next = drop || !full_read;
                    end
                end
            end
            ST_RUN:
            begin
                if (fire)
                begin
                    if ({1'b0, k_reg} < consume_reg)
                    begin
                        rp_next = rp_inc;
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == IDX_W'(ajb_pkg::BLOCK_FRAMES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rp_reg           <= '0;
            wp_reg           <= '0;
            fill_reg         <= '0;
            primed_reg       <= 1'b0;
            fade_pending_reg <= 1'b0;
            prime_reg        <= ajb_pkg::PRIME_RESET;
            thr_reg          <= ajb_pkg::THR_RESET;
            k_reg            <= '0;
            consume_reg      <= '0;
            use_reg          <= '0;
            silent_reg       <= 1'b0;
            fade_blk_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rp_reg           <= rp_next;
            wp_reg           <= wp_next;
            fill_reg         <= fill_next;
            primed_reg       <= primed_next;
            fade_pending_reg <= fade_pending_next;
            prime_reg        <= prime_next;
            thr_reg          <= thr_next;
            k_reg            <= k_next;
            consume_reg      <= consume_next;
            use_reg          <= use_next;
            silent_reg       <= silent_next;
            fade_blk_reg     <= fade_blk_next;
        end
    end

    `AJB_CHECK(fill_in_range_a, fill_reg <= FILL_W'(RING_DEPTH))
    `AJB_CHECK(read_in_run_a, !mem_re || (state_reg == ST_RUN))
    `AJB_CHECK_NEXT(pull_starts_block_a, pull, state_reg == ST_RUN)

endmodule

[src/ajb_out.sv]
`include "assert_macros.svh"

module ajb_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ajb_pkg::issue_t                     issue,
    input  logic [ajb_pkg::FRAME_W-1:0]         mem_rdata,
    output logic                                can_issue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ajb_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [ajb_pkg::SAMPLE_W-1:0] out_right,
    output logic                                block_end
);

    localparam int SW     = ajb_pkg::SAMPLE_W;
    localparam int IDX_W  = ajb_pkg::IDX_W;
    localparam int PROD_W = SW + IDX_W + 1;

    ajb_pkg::issue_t              st_reg;
    logic [ajb_pkg::FRAME_W-1:0]  held_reg;
    logic [SW-1:0]                fl_reg [2];
    logic [SW-1:0]                fr_reg [2];
    logic                         fe_reg [2];
    logic                         wptr_reg;
    logic                         rptr_reg;
    logic [1:0]                   occ_reg, occ_next;

    logic [ajb_pkg::FRAME_W-1:0]  frame;
    logic signed [PROD_W-1:0]     prod_l;
    logic signed [PROD_W-1:0]     prod_r;
    logic [SW-1:0]                res_l;
    logic [SW-1:0]                res_r;
    logic                         is_last;
    logic                         pop;
    logic [2:0]                   level;

    always_comb
    begin
        case (st_reg.src)
            ajb_pkg::SRC_RING: frame = mem_rdata;
            ajb_pkg::SRC_HELD: frame = held_reg;
            default:           frame = '0;
        endcase
    end

    assign prod_l = PROD_W'($signed(frame[SW-1:0])) * PROD_W'($signed({1'b0, st_reg.idx}));
    assign prod_r = PROD_W'($signed(frame[2*SW-1:SW])) * PROD_W'($signed({1'b0, st_reg.idx}));

    assign res_l = st_reg.fade ? prod_l[SW+IDX_W-1:IDX_W] : frame[SW-1:0];
    assign res_r = st_reg.fade ? prod_r[SW+IDX_W-1:IDX_W] : frame[2*SW-1:SW];

    assign is_last = st_reg.idx == IDX_W'(ajb_pkg::BLOCK_FRAMES - 1);

    assign out_valid = occ_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign out_left  = fl_reg[rptr_reg];
    assign out_right = fr_reg[rptr_reg];
    assign block_end = fe_reg[rptr_reg];

    assign level     = {1'b0, occ_reg} + {2'b0, st_reg.valid} - {2'b0, pop};
    assign can_issue = level < 3'd2;
    assign occ_next  = level[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            held_reg <= '0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            occ_reg  <= 2'd0;
        end
        else
        begin
            st_reg  <= issue;
            occ_reg <= occ_next;
            if (st_reg.valid && (st_reg.src == ajb_pkg::SRC_RING) && is_last)
            begin
                held_reg <= mem_rdata;
            end
            if (st_reg.valid)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg.valid)
        begin
            fl_reg[wptr_reg] <= res_l;
            fr_reg[wptr_reg] <= res_r;
            fe_reg[wptr_reg] <= is_last;
        end
    end

    `AJB_CHECK(fifo_bound_a, occ_reg <= 2'd2)
    `AJB_CHECK(no_overflow_a, !(st_reg.valid && (occ_reg == 2'd2) && !pop))

endmodule

[src/audio_jitter_buffer_output_core.sv]
// A push transaction returns nothing.
// A pull transaction yields 64 output transactions, the first once the sequencer is in its run
// state and the frame has passed the issue register and output FIFO, then one per cycle while
// the output is not stalled. The input side stays stalled until all 64 frames have been issued.
// Reset clears pointers, fill, priming, fade and held frame; ring contents stay undefined.
module audio_jitter_buffer_output_core #(
    parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [ajb_pkg::SAMPLE_W-1:0] in_left,
    input  logic signed [ajb_pkg::SAMPLE_W-1:0] in_right,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ajb_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [ajb_pkg::SAMPLE_W-1:0] out_right,
    output logic                                block_end,
    input  logic                                cfg_we,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ajb_pkg::CFG_W-1:0]           cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    ajb_pkg::issue_t             issue;
    logic                        can_issue;
    logic                        mem_we;
    logic [PTR_W-1:0]            mem_waddr;
    logic [ajb_pkg::FRAME_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [PTR_W-1:0]            mem_raddr;
    logic [ajb_pkg::FRAME_W-1:0] mem_rdata;

    ajb_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .in_left   (in_left),
        .in_right  (in_right),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .can_issue (can_issue),
        .issue     (issue),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    ajb_ram #(
        .WIDTH (ajb_pkg::FRAME_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ajb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .mem_rdata (mem_rdata),
        .can_issue (can_issue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_left  (out_left),
        .out_right (out_right),
        .block_end (block_end)
    );

endmodule
